>>> rtl/roman_pkg.sv
// Shared types, letter codes and digit helpers for the Roman numeral encoder.
`timescale 1ns / 1ps
`default_nettype none

package roman_pkg;

    localparam int unsigned NUM_W       = 12;
    localparam int unsigned LETTER_W    = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;

    localparam logic [LETTER_W-1:0] CH_C = 7'd67;
    localparam logic [LETTER_W-1:0] CH_D = 7'd68;
    localparam logic [LETTER_W-1:0] CH_I = 7'd73;
    localparam logic [LETTER_W-1:0] CH_L = 7'd76;
    localparam logic [LETTER_W-1:0] CH_M = 7'd77;
    localparam logic [LETTER_W-1:0] CH_V = 7'd86;
    localparam logic [LETTER_W-1:0] CH_X = 7'd88;
    localparam logic [LETTER_W-1:0] CH_NONE = 7'd0;

    // Digit places, most significant first
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] POS_TENS      = 2'd2;
    localparam logic [1:0] POS_UNITS     = 2'd3;

    typedef enum logic [1:0] {
        KIND_ONE  = 2'd0,
        KIND_FIVE = 2'd1,
        KIND_TEN  = 2'd2
    } roman_kind_t;

    // One classified number as it travels from front to back
    typedef struct packed {
        logic       err;
        logic [1:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } roman_item_t;

    // Quotient by 1000, 100 or 10 through a reciprocal multiply and shift.
    // Exact for the remainders that reach each step.
    function automatic logic [3:0] digit_quot(input logic [NUM_W-1:0] x,
                                              input logic [1:0] sel);
        logic [24:0] prod;
        logic [3:0]  q;
        prod = '0;
        q    = '0;
        case (sel)
            2'd0:
            begin
                prod = 25'(x) * 25'(13'd4195);
                q    = 4'(prod >> 22);
            end
            2'd1:
            begin
                prod = 25'(x) * 25'(13'd41);
                q    = 4'(prod >> 12);
            end
            2'd2:
            begin
                prod = 25'(x) * 25'(13'd205);
                q    = 4'(prod >> 11);
            end
            default:
            begin
                prod = '0;
                q    = '0;
            end
        endcase
        return q;
    endfunction

    function automatic logic [9:0] digit_div(input logic [1:0] sel);
        logic [9:0] d;
        case (sel)
            2'd0:    d = 10'd1000;
            2'd1:    d = 10'd100;
            2'd2:    d = 10'd10;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

    // Number of letters one digit produces
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        if (d == 4'd9 || d == 4'd4)
            n = 3'd2;
        else if (d >= 4'd5)
            n = 3'(d - 4'd4);
        else
            n = 3'(d);
        return n;
    endfunction

    function automatic roman_kind_t digit_kind(input logic [3:0] d,
                                               input logic [1:0] k);
        roman_kind_t kind;
        if (d == 4'd9)
            kind = (k == 2'd0) ? KIND_ONE : KIND_TEN;
        else if (d >= 4'd5)
            kind = (k == 2'd0) ? KIND_FIVE : KIND_ONE;
        else if (d == 4'd4)
            kind = (k == 2'd0) ? KIND_ONE : KIND_FIVE;
        else
            kind = KIND_ONE;
        return kind;
    endfunction

    function automatic logic [LETTER_W-1:0] roman_letter(input logic [1:0] pos,
                                                         input roman_kind_t kind);
        logic [LETTER_W-1:0] ch;
        ch = CH_NONE;
        case (pos)
            POS_THOUSANDS: ch = CH_M;
            POS_HUNDREDS:
            begin
                case (kind)
                    KIND_ONE:  ch = CH_C;
                    KIND_FIVE: ch = CH_D;
                    KIND_TEN:  ch = CH_M;
                    default:   ch = CH_NONE;
                endcase
            end
            POS_TENS:
            begin
                case (kind)
                    KIND_ONE:  ch = CH_X;
                    KIND_FIVE: ch = CH_L;
                    KIND_TEN:  ch = CH_C;
                    default:   ch = CH_NONE;
                endcase
            end
            POS_UNITS:
            begin
                case (kind)
                    KIND_ONE:  ch = CH_I;
                    KIND_FIVE: ch = CH_V;
                    KIND_TEN:  ch = CH_X;
                    default:   ch = CH_NONE;
                endcase
            end
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/int_to_roman_numeral_encoder_unit.sv
// Top level of the integer to Roman numeral encoder.
//
//   Channel  Valid      Stall      Payload
//   in       in_valid   in_stall   number[11:0]
//   out      out_valid  out_stall  letter[6:0], last, range_error
//
// The front end takes an in-range number through an accept state, three multiply/subtract
// digit steps (a divide state, then a subtract state) and a queue state that waits while
// the queue is full; an out-of-range number skips the digit steps. It takes no new number
// until it is idle again. The back end loads each number, then steps one letter per beat
// and skips each zero digit ahead of the last letter; the slower side sets the sustained rate.
// Reset clears the control state only; a stalled output beat holds while front and queue fill.
`timescale 1ns / 1ps
`default_nettype none

module int_to_roman_numeral_encoder_unit
    import roman_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [NUM_W-1:0]    number,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [LETTER_W-1:0]      letter,
    output logic                     last,
    output logic                     range_error
);

    logic        push_valid;
    logic        push_full;
    roman_item_t push_item;
    logic        pop_valid;
    logic        pop;
    roman_item_t pop_item;

    roman_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_item  (push_item)
    );

    roman_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    roman_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .letter      (letter),
        .last        (last),
        .range_error (range_error)
    );

endmodule

`default_nettype wire

>>> rtl/roman_front.sv
// Front end: accepts a number, range-checks it and splits it into decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module roman_front
    import roman_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [NUM_W-1:0] number,
    output logic                  push_valid,
    input  wire logic             push_full,
    output roman_item_t           push_item
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_SUB  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [1:0]   sel_reg, sel_next;
    logic [NUM_W-1:0] x_reg, x_next;
    logic [3:0]   q_reg, q_next;
    roman_item_t  item_reg, item_next;
    logic [NUM_W-1:0] rem;

    assign in_stall   = (state_reg != F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = item_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        item_next  = item_reg;
        rem        = x_reg - NUM_W'(14'(q_reg) * 14'(digit_div(sel_reg)));
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    item_next     = '0;
                    item_next.err = (number == '0) || (number > NUM_MAX);
                    x_next        = number;
                    sel_next      = 2'd0;
                    state_next    = item_next.err ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                q_next     = digit_quot(x_reg, sel_reg);
                state_next = F_SUB;
            end
            F_SUB:
            begin
                x_next = rem;
                case (sel_reg)
                    2'd0:    item_next.thousands = q_reg[1:0];
                    2'd1:    item_next.hundreds  = q_reg;
                    2'd2:
                    begin
                        item_next.tens  = q_reg;
                        item_next.units = rem[3:0];
                    end
                    default: item_next = item_reg;
                endcase
                if (sel_reg == 2'd2)
                    state_next = F_PUSH;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = F_DIV;
                end
            end
            F_PUSH:
            begin
                if (!push_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        x_reg    <= x_next;
        q_reg    <= q_next;
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

>>> rtl/roman_queue.sv
// Short queue of classified numbers between front end and letter sequencer.
`timescale 1ns / 1ps
`default_nettype none

module roman_queue
    import roman_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_full,
    input  wire roman_item_t push_item,
    output logic             pop_valid,
    input  wire logic        pop,
    output roman_item_t      pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    roman_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_full = (cnt_reg == CNT_FULL);
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = mem[rd_reg];
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_item;
    end

endmodule

`default_nettype wire

>>> rtl/roman_back.sv
// Back end: walks the digits of one number and emits its letters one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module roman_back
    import roman_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pop_valid,
    output logic                     pop,
    input  wire roman_item_t         pop_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [LETTER_W-1:0]      letter,
    output logic                     last,
    output logic                     range_error
);

    logic       busy_reg, busy_next;
    logic       err_reg, err_next;
    logic [3:0] d_reg [4];
    logic [3:0] d_next [4];
    logic [1:0] pos_reg, pos_next;
    logic [1:0] k_reg, k_next;

    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                last_reg, last_next;
    logic                err_out_reg, err_out_next;

    logic       adv;
    logic       emit;
    logic [3:0] cur_d;
    logic [2:0] cur_len;
    logic       digit_done;
    logic       later_nz;

    assign out_valid   = out_valid_reg;
    assign letter      = letter_reg;
    assign last        = last_reg;
    assign range_error = err_out_reg;

    // The output register moves on when empty or when its beat is taken
    assign adv        = !out_valid_reg || !out_stall;
    assign cur_d      = d_reg[pos_reg];
    assign cur_len    = digit_len(cur_d);
    assign digit_done = ({1'b0, k_reg} + 3'd1) == cur_len;
    assign pop        = !busy_reg && pop_valid;

    always_comb
    begin
        later_nz = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (2'(j) > pos_reg && d_reg[j] != 4'd0)
                later_nz = 1'b1;
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        err_next     = err_reg;
        d_next       = d_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        emit         = 1'b0;
        letter_next  = letter_reg;
        last_next    = last_reg;
        err_out_next = err_out_reg;

        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                busy_next = 1'b1;
                err_next  = pop_item.err;
                d_next[0] = {2'b00, pop_item.thousands};
                d_next[1] = pop_item.hundreds;
                d_next[2] = pop_item.tens;
                d_next[3] = pop_item.units;
                pos_next  = POS_THOUSANDS;
                k_next    = 2'd0;
            end
        end
        else if (adv)
        begin
            if (err_reg)
            begin
                emit         = 1'b1;
                letter_next  = CH_NONE;
                last_next    = 1'b1;
                err_out_next = 1'b1;
                busy_next    = 1'b0;
            end
            else if (cur_len == 3'd0)
            begin
                // skip a zero digit
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                emit         = 1'b1;
                letter_next  = roman_letter(pos_reg, digit_kind(cur_d, k_reg));
                last_next    = digit_done && !later_nz;
                err_out_next = 1'b0;
                if (digit_done)
                begin
                    k_next   = 2'd0;
                    pos_next = pos_reg + 2'd1;
                    if (!later_nz)
                        busy_next = 1'b0;
                end
                else
                    k_next = k_reg + 2'd1;
            end
        end

        out_valid_next = adv ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        d_reg       <= d_next;
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        letter_reg  <= letter_next;
        last_reg    <= last_next;
        err_out_reg <= err_out_next;
    end

endmodule

`default_nettype wire
